@@ design/miller_rabin_prime_test_top_assert.svh @@
// Assertion macros for the Miller-Rabin prime test block
`ifndef MILLER_RABIN_PRIME_TEST_TOP_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_TOP_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define MRPT_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define MRPT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/mrpt_pkg.sv @@
// Shared types and constants for the Miller-Rabin prime test block
`default_nettype none

package mrpt_pkg;

	localparam int IN_W = 32;

	typedef enum logic [1:0] {
		OP_RED,
		OP_ACC,
		OP_SQB,
		OP_SQX
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    strip;
		logic    exp_shift;
		logic    j_init;
		logic    j_inc;
		logic    mul_start;
		mul_op_t mul_op;
		logic    finish;
	} mrpt_cmd_t;

	typedef struct packed {
		logic small_fail;
		logic small_pass;
		logic d_odd;
		logic e_zero;
		logic e_one;
		logic e_lsb;
		logic x_one;
		logic x_nm1;
		logic j_lt_r;
		logic mul_done;
	} mrpt_sts_t;

endpackage

`default_nettype wire

@@ design/mrpt_in_if.sv @@
// Input channel: candidate, witness and group-end flag
`default_nettype none

interface mrpt_in_if import mrpt_pkg::*;;
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] number;
	logic [IN_W-1:0] witness;
	logic            last_witness;

	modport source (output valid, number, witness, last_witness, input ready);
	modport sink (input valid, number, witness, last_witness, output ready);
endinterface

`default_nettype wire

@@ design/mrpt_out_if.sv @@
// Output channel: verdict of a witness group
`default_nettype none

interface mrpt_out_if;
	logic valid;
	logic ready;
	logic verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

`default_nettype wire

@@ design/mrpt_mulmod.sv @@
// Shift-add modular multiplier, per multiplier bit a doubling and an add
`default_nettype none

module mrpt_mulmod import mrpt_pkg::*; #(
	parameter int NUM_WIDTH = 32,
	parameter int OP_WIDTH  = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_WIDTH-1:0] x,
	input  wire logic [OP_WIDTH-1:0]  y,
	input  wire logic [NUM_WIDTH-1:0] m,
	output logic                      done,
	output logic [NUM_WIDTH-1:0]      res
);

	localparam int CW = $clog2(OP_WIDTH);

	// (a + b) mod m for a, b < m
	function automatic logic [NUM_WIDTH-1:0] add_mod(
		input logic [NUM_WIDTH-1:0] a,
		input logic [NUM_WIDTH-1:0] b,
		input logic [NUM_WIDTH-1:0] md
	);
		logic [NUM_WIDTH-1:0] gap;
		gap = md - b;
		return (a >= gap) ? (a - gap) : (a + b);
	endfunction

	logic                 busy_q;
	logic                 phase_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [NUM_WIDTH-1:0] x_q;
	logic [OP_WIDTH-1:0]  y_q;
	logic [NUM_WIDTH-1:0] acc_q;
	logic [NUM_WIDTH-1:0] add_b;

	// phase 0 doubles, phase 1 adds x when the current multiplier bit is set
	assign add_b = phase_q ? x_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CW'(OP_WIDTH - 1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				acc_q <= add_mod(acc_q, add_b, m);
			end else begin
				if (y_q[OP_WIDTH-1]) begin
					acc_q <= add_mod(acc_q, add_b, m);
				end
				y_q <= {y_q[OP_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

`default_nettype wire

@@ design/mrpt_dp.sv @@
// Datapath: operand registers, exponent split and the modular multiplier
`default_nettype none

module mrpt_dp import mrpt_pkg::*; #(
	parameter int NUM_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mrpt_cmd_t       cmd,
	input  wire logic [IN_W-1:0] number,
	input  wire logic [IN_W-1:0] witness,
	output mrpt_sts_t            sts
);

	localparam int MW = (NUM_WIDTH > IN_W) ? NUM_WIDTH : IN_W;
	localparam int RW = $clog2(NUM_WIDTH);

	logic [MW-1:0]        num_ext;
	logic [NUM_WIDTH-1:0] n_in;
	logic [NUM_WIDTH-1:0] n_q;
	logic [IN_W-1:0]      w_q;
	logic [NUM_WIDTH-1:0] d_q;
	logic [RW-1:0]        r_q;
	logic [RW-1:0]        j_q;
	logic [NUM_WIDTH-1:0] base_q;
	logic [NUM_WIDTH-1:0] acc_q;
	mul_op_t              op_q;

	logic [NUM_WIDTH-1:0] mul_x;
	logic [MW-1:0]        mul_y;
	logic                 mul_done;
	logic [NUM_WIDTH-1:0] mul_res;

	assign num_ext = MW'(number);
	assign n_in    = num_ext[NUM_WIDTH-1:0];

	always_comb begin
		case (cmd.mul_op)
			OP_RED: begin
				mul_x = NUM_WIDTH'(1);
				mul_y = MW'(w_q);
			end
			OP_ACC: begin
				mul_x = acc_q;
				mul_y = MW'(base_q);
			end
			OP_SQB: begin
				mul_x = base_q;
				mul_y = MW'(base_q);
			end
			OP_SQX: begin
				mul_x = acc_q;
				mul_y = MW'(acc_q);
			end
			default: begin
				mul_x = acc_q;
				mul_y = MW'(acc_q);
			end
		endcase
	end

	mrpt_mulmod #(
		.NUM_WIDTH (NUM_WIDTH),
		.OP_WIDTH  (MW)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.m      (n_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= n_in;
			w_q   <= witness;
			d_q   <= n_in - NUM_WIDTH'(1);
			r_q   <= '0;
			acc_q <= NUM_WIDTH'(1);
		end
		if (cmd.strip) begin
			d_q <= d_q >> 1;
			r_q <= r_q + RW'(1);
		end
		if (cmd.exp_shift) begin
			d_q <= d_q >> 1;
		end
		if (cmd.j_init) begin
			j_q <= RW'(1);
		end
		if (cmd.j_inc) begin
			j_q <= j_q + RW'(1);
		end
		if (cmd.mul_start) begin
			op_q <= cmd.mul_op;
		end
		if (mul_done) begin
			case (op_q)
				OP_RED, OP_SQB: base_q <= mul_res;
				OP_ACC, OP_SQX: acc_q  <= mul_res;
				default:        acc_q  <= mul_res;
			endcase
		end
	end

	assign sts.small_fail = (n_q <= NUM_WIDTH'(1)) || (n_q == NUM_WIDTH'(4));
	assign sts.small_pass = (n_q == NUM_WIDTH'(2)) || (n_q == NUM_WIDTH'(3));
	assign sts.d_odd      = d_q[0];
	assign sts.e_zero     = (d_q == '0);
	assign sts.e_one      = (d_q == NUM_WIDTH'(1));
	assign sts.e_lsb      = d_q[0];
	assign sts.x_one      = (acc_q == NUM_WIDTH'(1));
	assign sts.x_nm1      = (acc_q == (n_q - NUM_WIDTH'(1)));
	assign sts.j_lt_r     = (j_q < r_q);
	assign sts.mul_done   = mul_done;

endmodule

`default_nettype wire

@@ design/mrpt_ctrl.sv @@
// Controller: sequences one witness round and the group verdict
`default_nettype none

module mrpt_ctrl import mrpt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      last,
	input  wire logic      out_free,
	input  wire mrpt_sts_t sts,
	output logic           in_ready,
	output mrpt_cmd_t      cmd,
	output logic           fail
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLASS  = 4'd1;
	localparam logic [3:0] S_STRIP  = 4'd2;
	localparam logic [3:0] S_RED_W  = 4'd3;
	localparam logic [3:0] S_POW    = 4'd4;
	localparam logic [3:0] S_POW_MA = 4'd5;
	localparam logic [3:0] S_POW_SH = 4'd6;
	localparam logic [3:0] S_POW_SB = 4'd7;
	localparam logic [3:0] S_CHK    = 4'd8;
	localparam logic [3:0] S_SQ     = 4'd9;
	localparam logic [3:0] S_SQ_W   = 4'd10;
	localparam logic [3:0] S_SQ_T   = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       fail_q;
	logic       fail_d;

	always_comb begin
		state_d  = state_q;
		fail_d   = fail_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.mul_op = OP_RED;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLASS;
				end
			end
			S_CLASS: begin
				if (sts.small_fail) begin
					fail_d  = 1'b1;
					state_d = S_FIN;
				end else if (sts.small_pass) begin
					fail_d  = 1'b0;
					state_d = S_FIN;
				end else begin
					state_d = S_STRIP;
				end
			end
			S_STRIP: begin
				if (sts.d_odd) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = OP_RED;
					state_d       = S_RED_W;
				end else begin
					cmd.strip = 1'b1;
				end
			end
			S_RED_W: begin
				if (sts.mul_done) begin
					state_d = S_POW;
				end
			end
			S_POW: begin
				if (sts.e_zero) begin
					state_d = S_CHK;
				end else if (sts.e_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = OP_ACC;
					state_d       = S_POW_MA;
				end else begin
					state_d = S_POW_SH;
				end
			end
			S_POW_MA: begin
				if (sts.mul_done) begin
					state_d = S_POW_SH;
				end
			end
			S_POW_SH: begin
				cmd.exp_shift = 1'b1;
				if (sts.e_one) begin
					state_d = S_CHK;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = OP_SQB;
					state_d       = S_POW_SB;
				end
			end
			S_POW_SB: begin
				if (sts.mul_done) begin
					state_d = S_POW;
				end
			end
			S_CHK: begin
				if (sts.x_one || sts.x_nm1) begin
					fail_d  = 1'b0;
					state_d = S_FIN;
				end else begin
					cmd.j_init = 1'b1;
					state_d    = S_SQ;
				end
			end
			S_SQ: begin
				if (sts.j_lt_r) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = OP_SQX;
					state_d       = S_SQ_W;
				end else begin
					fail_d  = 1'b1;
					state_d = S_FIN;
				end
			end
			S_SQ_W: begin
				if (sts.mul_done) begin
					state_d = S_SQ_T;
				end
			end
			S_SQ_T: begin
				if (sts.x_nm1) begin
					fail_d  = 1'b0;
					state_d = S_FIN;
				end else begin
					cmd.j_inc = 1'b1;
					state_d   = S_SQ;
				end
			end
			S_FIN: begin
				// a verdict waits here only while the output register is full
				if (!last || out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fail_q  <= fail_d;
		end
	end

	assign fail = fail_q;

endmodule

`default_nettype wire

@@ design/miller_rabin_prime_test_top.sv @@
// Top level of the Miller-Rabin prime test block
//
// Channels: item (sink) carries number, witness and last_witness; result
// (source) carries verdict, 1 for probably prime and 0 for composite. A
// transfer happens on a rising edge with valid and ready both high.
// One item is one witness round; items are taken one at a time. The round
// runs on a single shift-add modular multiplier with an MW-bit multiplier,
// MW being the larger of NUM_WIDTH and 32. A round costs one witness
// reduction, up to two products per bit of the odd part d of number-1, and
// up to r-1 squarings; numbers up to 4 need no product. item.ready is high
// again the cycle after the round finishes; a group's last round finishes
// only when the output register is free.
// A group of items ends at last_witness; its verdict is loaded into an
// output register when that round ends. The register lets the next item
// in while the verdict waits; a stalled result only holds back the end of
// the following group's last round.
// Reset clears the sticky composite flag, the output valid flag and the
// controller; no result is pending after reset.
`default_nettype none

module miller_rabin_prime_test_top import mrpt_pkg::*; #(
	parameter int NUM_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mrpt_in_if.sink     item,
	mrpt_out_if.source  result
);

`include "miller_rabin_prime_test_top_assert.svh"

	mrpt_cmd_t cmd;
	mrpt_sts_t sts;
	logic      fail;
	logic      out_free;
	logic      last_q;
	logic      sticky_q;
	logic      out_valid_q;
	logic      verdict_q;

	// verdict register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || result.ready;

	mrpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.last     (last_q),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (item.ready),
		.cmd      (cmd),
		.fail     (fail)
	);

	mrpt_dp #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.number  (item.number),
		.witness (item.witness),
		.sts     (sts)
	);

	// group bookkeeping: sticky composite flag and the verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			sticky_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_q <= item.last_witness;
			end
			if (cmd.finish) begin
				sticky_q <= last_q ? 1'b0 : (sticky_q | fail);
			end
			if (cmd.finish && last_q) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && last_q) begin
			verdict_q <= !(sticky_q | fail);
		end
	end

	assign result.valid   = out_valid_q;
	assign result.verdict = verdict_q;

	// group end never overwrites a verdict still waiting
	`MRPT_ASSERT_SAME(a_fin_free, clk, arst_n, cmd.finish && last_q, out_free, "verdict overwritten")
	// verdict reflects every round of the group
	`MRPT_ASSERT_NEXT(a_emit, clk, arst_n, cmd.finish && last_q, result.valid && (result.verdict == !$past(sticky_q || fail)), "wrong verdict")
	// the next group starts clean
	`MRPT_ASSERT_NEXT(a_clear, clk, arst_n, cmd.finish && last_q, !sticky_q, "sticky flag kept")
	// one round at a time
	`MRPT_ASSERT_NEXT(a_one, clk, arst_n, item.valid && item.ready, !item.ready, "item taken mid-round")

endmodule

`default_nettype wire

@@ sim/tb_miller_rabin_prime_test_top.sv @@
// Testbench for the Miller-Rabin prime test block: directed and random witness groups
`default_nettype none

module tb_miller_rabin_prime_test_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mrpt_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 8;
	localparam int TOTAL_ROUNDS = 140;
	// drain time: room for one full round at 32 bits, with margin on top
	localparam int DRAIN_CYCLES = 5000;
	// long receiver hold-off: spans several group ends so the output
	// register fills and the item channel backs up
	localparam int HOLD_CYCLES  = 20000;
	localparam int HOLD_AFTER   = 12;
	localparam int MAX_REPORTS  = 10;

	// verdict codes
	localparam logic COMPOSITE = 1'b0;
	localparam logic PRIME     = 1'b1;
	// group marker
	localparam logic MORE      = 1'b0;
	localparam logic LAST      = 1'b1;
	// where a directed row's expectation comes from
	localparam logic MODEL     = 1'b0;
	localparam logic FIXED     = 1'b1;

	typedef struct packed {
		logic [IN_W-1:0] number;
		logic [IN_W-1:0] witness;
		logic            last;
		logic            fixed;
		logic            verdict;
	} dir_row_t;

	localparam int N_DIRECTED = 25;

	// verdict column only counts where fixed is set
	localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// numbers up to 4: fixed outcome whatever the witness
		'{32'd0,           32'd0,           LAST, FIXED, COMPOSITE},
		'{32'd1,           32'hFFFF_FFFF,   LAST, FIXED, COMPOSITE},
		'{32'd2,           32'd0,           LAST, FIXED, PRIME},
		'{32'd3,           32'hFFFF_FFFF,   LAST, FIXED, PRIME},
		'{32'd4,           32'd3,           LAST, FIXED, COMPOSITE},
		// sticky flag carried across a number change within the group
		'{32'd4,           32'd2,           MORE, MODEL, COMPOSITE},
		'{32'd3,           32'd2,           LAST, FIXED, COMPOSITE},
		// witness residue 0, 1 and n-1
		'{32'd7,           32'd14,          LAST, FIXED, COMPOSITE},
		'{32'd9,           32'd1,           LAST, FIXED, PRIME},
		'{32'd15,          32'd14,          LAST, FIXED, PRIME},
		// even numbers above 4: no squaring stage
		'{32'd6,           32'd5,           LAST, FIXED, PRIME},
		'{32'd6,           32'd2,           LAST, MODEL, COMPOSITE},
		// largest 32-bit prime, witness above n and witness n-1
		'{32'hFFFF_FFFB,   32'd2,           MORE, MODEL, COMPOSITE},
		'{32'hFFFF_FFFB,   32'hFFFF_FFFF,   MORE, MODEL, COMPOSITE},
		'{32'hFFFF_FFFB,   32'hFFFF_FFFA,   LAST, MODEL, COMPOSITE},
		'{32'hFFFF_FFFF,   32'd2,           LAST, MODEL, COMPOSITE},
		// strong pseudoprimes and a Carmichael number
		'{32'd2047,        32'd2,           LAST, MODEL, COMPOSITE},
		'{32'd2047,        32'd3,           LAST, MODEL, COMPOSITE},
		'{32'd561,         32'd2,           LAST, MODEL, COMPOSITE},
		'{32'd25326001,    32'd2,           MORE, MODEL, COMPOSITE},
		'{32'd25326001,    32'd3,           MORE, MODEL, COMPOSITE},
		'{32'd25326001,    32'd5,           LAST, MODEL, COMPOSITE},
		'{32'd25326001,    32'd7,           LAST, MODEL, COMPOSITE},
		'{32'h8000_0000,   32'd3,           LAST, MODEL, COMPOSITE},
		'{32'hFFFF_FFFE,   32'hFFFF_FFFD,   LAST, MODEL, COMPOSITE}
	};

	logic clk = 1'b0;
	logic arst_n;

	mrpt_in_if  item_ch ();
	mrpt_out_if result_ch ();

	miller_rabin_prime_test_top #(
		.NUM_WIDTH(32)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor: exact modular arithmetic on 64-bit products
	// ---------------------------------------------------------------
	logic pending_verdicts [$];   // verdicts owed by the block, oldest first
	logic group_composite;        // some round of the open group failed
	int   mismatch_count;
	int   rounds_sent;
	int   burst_left;

	function automatic bit [63:0] mod_mul(bit [63:0] a, bit [63:0] b, bit [63:0] m);
		return (a * b) % m;   // a, b < m < 2^32, so the product fits
	endfunction

	function automatic bit [63:0] mod_pow(bit [63:0] base, bit [63:0] e, bit [63:0] m);
		bit [63:0] acc;
		acc = 64'd1;
		while (e != 64'd0) begin
			if (e[0])
				acc = mod_mul(acc, base, m);
			e = e >> 1;
			base = mod_mul(base, base, m);
		end
		return acc;
	endfunction

	// 1 when this witness proves n composite
	function automatic bit round_composite(bit [31:0] n, bit [31:0] w);
		bit [63:0] nm1, d, x;
		int        r;
		if (n <= 32'd1 || n == 32'd4)
			return 1'b1;
		if (n <= 32'd3)
			return 1'b0;
		nm1 = 64'(n) - 64'd1;
		d = nm1;
		r = 0;
		while (!d[0]) begin
			d = d >> 1;
			r++;
		end
		x = mod_pow(64'(w) % 64'(n), d, 64'(n));
		if (x == 64'd1 || x == nm1)
			return 1'b0;
		for (int j = 1; j < r; j++) begin
			x = mod_mul(x, x, 64'(n));
			if (x == nm1)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// bases 2, 7 and 61 settle primality for every 32-bit n >= 67
	function automatic bit [31:0] next_prime(bit [31:0] start);
		bit [31:0] c;
		c = start | 32'd1;
		while (round_composite(c, 32'd2) || round_composite(c, 32'd7) ||
				round_composite(c, 32'd61))
			c += 32'd2;
		return c;
	endfunction

	task automatic log_round(logic [31:0] n, logic [31:0] w, logic lw, logic fixed,
			logic fixed_verdict);
		if (round_composite(n, w))
			group_composite = 1'b1;
		if (lw) begin
			pending_verdicts.push_back(fixed ? fixed_verdict : !group_composite);
			group_composite = 1'b0;
		end
	endtask

	task automatic flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%t: %s", $realtime, msg);
	endtask

	// ---------------------------------------------------------------
	// Sender: offer one round and wait for its transfer; bursts of
	// random length separated by random gaps
	// ---------------------------------------------------------------
	task automatic send_round(logic [31:0] n, logic [31:0] w, logic lw,
			logic fixed = MODEL, logic fixed_verdict = COMPOSITE);
		int gap;
		item_ch.valid        <= 1'b1;
		item_ch.number       <= n;
		item_ch.witness      <= w;
		item_ch.last_witness <= lw;
		do
			@(posedge clk);
		while (!item_ch.ready);
		log_round(n, w, lw, fixed, fixed_verdict);
		rounds_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		int          kind;
		int          group_len;
		logic [31:0] n;
		logic [31:0] w;

		arst_n               <= 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.number       <= '0;
		item_ch.witness      <= '0;
		item_ch.last_witness <= 1'b0;
		group_composite = 1'b0;
		mismatch_count  = 0;
		rounds_sent     = 0;
		burst_left      = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (DIRECTED_ROWS[i])
			send_round(DIRECTED_ROWS[i].number, DIRECTED_ROWS[i].witness,
				DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].fixed,
				DIRECTED_ROWS[i].verdict);

		// random part: mostly well-formed groups (one number, witnesses in
		// 2..n-2, last flag on the final round), some noise rounds with any
		// number, any witness and a random last flag. Small numbers keep the
		// rounds short; large ones toggle the upper bits.
		while (rounds_sent < TOTAL_ROUNDS) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				n = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 40);
				send_round(n, $urandom(), 1'($urandom_range(0, 1)));
			end else begin
				case (kind)
					2, 3, 4: n = next_prime($urandom_range(67, 4000));
					5:       n = next_prime($urandom_range(32'h8000_0000, 32'hFFFF_FF00));
					6, 7:    n = $urandom_range(5, 4095) | 32'd1;
					8:       n = $urandom();
					default: n = $urandom_range(0, 40);
				endcase
				group_len = $urandom_range(1, 4);
				for (int k = 0; k < group_len; k++) begin
					w = (n > 32'd4) ? $urandom_range(2, n - 32'd2) : $urandom();
					send_round(n, w, (k == group_len - 1) ? LAST : MORE);
				end
			end
		end
		item_ch.valid <= 1'b0;

		// wait for every owed verdict, then let any trailing round finish so a
		// stray transfer would still be caught
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ---------------------------------------------------------------
	// Receiver: stretches of full readiness alternate with random
	// stalls; once, after a few transfers, a long hold-off
	// ---------------------------------------------------------------
	initial begin
		int        rx_transfers;
		int        hold_left;
		bit        held;
		bit [15:0] rx_cycle;

		rx_transfers = 0;
		hold_left    = 0;
		held         = 1'b0;
		rx_cycle     = '0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				rx_transfers++;
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!held && rx_transfers >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (rx_cycle[7:6] == 2'd0) begin
				result_ch.ready <= 1'b1;   // stall-free stretch
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= 35);
			end
		end
	end

	// ---------------------------------------------------------------
	// Checker: each verdict transfer against the oldest owed verdict
	// ---------------------------------------------------------------
	logic owed_verdict;

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				flag_error($sformatf("verdict %0b with none owed", result_ch.verdict));
			end else begin
				owed_verdict = pending_verdicts.pop_front();
				if (result_ch.verdict !== owed_verdict)
					flag_error($sformatf("verdict: expected %0b, got %0b",
						owed_verdict, result_ch.verdict));
			end
		end
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#60ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
